### rtl/fbrf_pkg.sv
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared types and codes of the rectangle fill engine: request codes,
// register indexes, the classified command word and the result word.
// ----------------------------------------------------------------------------
package fbrf_pkg;

  // Request codes as they arrive on req_type.
  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_FILL   = 3'd2;
  localparam logic [2:0] REQ_INVERT = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam int          CFG_INDEX_W      = 4;
  localparam logic [3:0]  REG_LINE_WIDTH   = 4'd0;
  localparam logic [3:0]  REG_FRAME_HEIGHT = 4'd1;
  localparam int          CFG_DATA_W       = 9;

  // Coordinates inside the engine cover a full line of up to 511 pixels.
  localparam int COORD_W = 9;
  // Widest pixel address that a 511 by 511 frame can produce.
  localparam int ADDR_W  = 18;

  // Queue depths between front, back and the result side.
  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  // Operations after classification; a clear becomes a full-frame fill.
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_FILL   = 3'd2,
    OP_INVERT = 3'd3,
    OP_REJECT = 3'd4
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] y_last;
    logic [7:0]         color;
    logic [ADDR_W-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       status;
  } res_t;

endpackage

### rtl/framebuffer_rect_fill_engine_top.sv
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_engine_top
// 8-bit-per-pixel framebuffer engine: pixel write and read, rectangle fill,
// rectangle invert and full-frame clear, one result word per request.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and results leave
// through another (empty/pop); every request word produces exactly one
// result word, in order. The front checks a request against the frame set
// by line_width and frame_height and computes its start address; a four-
// entry command queue then decouples it from the back, which owns the
// pixel memory, with one write port and one read port, and walks the
// pixels. The memory's one write per cycle sets the fill rate, and the
// read-then-write of each pixel sets the invert rate. New requests keep
// being accepted while the command queue has room. A finished result waits
// in a two-entry result queue, and the back starts no new command while
// that queue is full. A rectangle with its last corner before its first,
// any coordinate outside the frame, or an unknown request type is answered
// with status 1 and leaves the memory untouched; read_value is zero except
// for a read. Pixel memory is not initialized: reading a pixel never
// written returns an arbitrary value. The user must write configuration only
// while the engine is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [2:0]                       req_type,
  input  logic [7:0]                       x_first,
  input  logic [7:0]                       y_first,
  input  logic [7:0]                       x_last,
  input  logic [7:0]                       y_last,
  input  logic [7:0]                       color,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       read_value,
  output logic                             status,
  input  logic                             cfg_we,
  input  logic [fbrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // The 9-bit registers cap the usable frame at 511 by 511 pixels, so the
  // memory only needs to cover the part of the maximum frame that is reachable.
  localparam int REACH_W   = (MAX_WIDTH  < 511) ? MAX_WIDTH  : 511;
  localparam int REACH_H   = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int MEM_DEPTH = REACH_W * REACH_H;

  fbrf_pkg::cmd_t               front_cmd;
  fbrf_pkg::cmd_t               back_cmd;
  logic [$bits(fbrf_pkg::cmd_t)-1:0] back_cmd_bits;
  logic [fbrf_pkg::COORD_W-1:0] stride;
  logic                         cmdq_empty;
  logic                         cmd_pop;
  logic                         resq_full;
  logic                         res_push;
  fbrf_pkg::res_t               back_res;
  fbrf_pkg::res_t               out_res;
  logic [$bits(fbrf_pkg::res_t)-1:0] out_res_bits;

  fbrf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .x_first   (x_first),
    .y_first   (y_first),
    .x_last    (x_last),
    .y_last    (y_last),
    .color     (color),
    .cmd       (front_cmd),
    .stride    (stride)
  );

  // Command queue: a request word is accepted when it enters here.
  fbrf_fifo #(
    .WIDTH ($bits(fbrf_pkg::cmd_t)),
    .DEPTH (fbrf_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_cmd),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (back_cmd_bits),
    .empty   (cmdq_empty)
  );

  assign back_cmd = fbrf_pkg::cmd_t'(back_cmd_bits);

  fbrf_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmdq_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .stride    (stride),
    .res_room  (!resq_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // The back only starts a command when the result queue has room, so its
  // result push never meets a full queue.
  fbrf_fifo #(
    .WIDTH ($bits(fbrf_pkg::res_t)),
    .DEPTH (fbrf_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_res),
    .full    (resq_full),
    .pop     (pop),
    .rd_data (out_res_bits),
    .empty   (empty)
  );

  assign out_res    = fbrf_pkg::res_t'(out_res_bits);
  assign read_value = out_res.read_value;
  assign status     = out_res.status;

endmodule

### rtl/fbrf_fifo.sv
// ----------------------------------------------------------------------------
// fbrf_fifo
// Small register queue used between the engine's parts and on its output.
// ----------------------------------------------------------------------------
module fbrf_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

### rtl/fbrf_front.sv
// ----------------------------------------------------------------------------
// fbrf_front
// Holds the frame registers, checks each request against the frame and
// turns it into a command word with its start address.
// ----------------------------------------------------------------------------
module fbrf_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fbrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fbrf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [2:0]                        req_type,
  input  logic [7:0]                        x_first,
  input  logic [7:0]                        y_first,
  input  logic [7:0]                        x_last,
  input  logic [7:0]                        y_last,
  input  logic [7:0]                        color,
  output fbrf_pkg::cmd_t                    cmd,
  output logic [fbrf_pkg::COORD_W-1:0]      stride
);

  logic [8:0] line_width;
  logic [8:0] frame_height;
  logic [8:0] w_eff;
  logic [8:0] h_eff;
  logic       pix_bad;
  logic       rect_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 9'd256;
      frame_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        fbrf_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data;
        fbrf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Registers outside their range are used clamped; zero counts as one.
  always_comb begin
    if (line_width == '0) begin
      w_eff = 9'd1;
    end else if (32'(line_width) > MAX_WIDTH) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    if (frame_height == '0) begin
      h_eff = 9'd1;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign stride   = w_eff;
  assign pix_bad  = ({1'b0, x_first} >= w_eff) || ({1'b0, y_first} >= h_eff);
  assign rect_bad = (x_last < x_first) || (y_last < y_first) ||
                    ({1'b0, x_last} >= w_eff) || ({1'b0, y_last} >= h_eff);

  always_comb begin
    cmd.x_first = {1'b0, x_first};
    cmd.x_last  = {1'b0, x_last};
    cmd.y_first = {1'b0, y_first};
    cmd.y_last  = {1'b0, y_last};
    cmd.color   = color;
    cmd.addr    = fbrf_pkg::ADDR_W'(w_eff) * fbrf_pkg::ADDR_W'(y_first)
                + fbrf_pkg::ADDR_W'(x_first);
    case (req_type)
      fbrf_pkg::REQ_WRITE:  cmd.op = pix_bad  ? fbrf_pkg::OP_REJECT : fbrf_pkg::OP_WRITE;
      fbrf_pkg::REQ_READ:   cmd.op = pix_bad  ? fbrf_pkg::OP_REJECT : fbrf_pkg::OP_READ;
      fbrf_pkg::REQ_FILL:   cmd.op = rect_bad ? fbrf_pkg::OP_REJECT : fbrf_pkg::OP_FILL;
      fbrf_pkg::REQ_INVERT: cmd.op = rect_bad ? fbrf_pkg::OP_REJECT : fbrf_pkg::OP_INVERT;
      fbrf_pkg::REQ_CLEAR: begin
        // The whole frame, walked as one rectangle, covers 0 .. w*h-1.
        cmd.op      = fbrf_pkg::OP_FILL;
        cmd.x_first = '0;
        cmd.y_first = '0;
        cmd.x_last  = w_eff - 1'b1;
        cmd.y_last  = h_eff - 1'b1;
        cmd.addr    = '0;
      end
      default: cmd.op = fbrf_pkg::OP_REJECT;
    endcase
  end

endmodule

### rtl/fbrf_back.sv
// ----------------------------------------------------------------------------
// fbrf_back
// Pixel memory and the sequencer that carries out one command at a time,
// one pixel per cycle for fills; inverts read and then write each pixel.
// ----------------------------------------------------------------------------
module fbrf_back #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  fbrf_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  input  logic [fbrf_pkg::COORD_W-1:0] stride,
  input  logic                         res_room,
  output logic                         res_push,
  output fbrf_pkg::res_t               res
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_INV_RD = 5'b01000,
    ST_INV_WR = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata;
  logic       mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0] mem_wdata;

  logic [fbrf_pkg::ADDR_W-1:0]  cur;
  logic [fbrf_pkg::ADDR_W-1:0]  row;
  logic [fbrf_pkg::COORD_W-1:0] x;
  logic [fbrf_pkg::COORD_W-1:0] y;
  logic [fbrf_pkg::COORD_W-1:0] x_first;
  logic [fbrf_pkg::COORD_W-1:0] x_last;
  logic [fbrf_pkg::COORD_W-1:0] y_last;
  logic [7:0]                   color;

  logic start;
  logic step;
  logic last_col;
  logic last_pix;
  logic [fbrf_pkg::ADDR_W-1:0] next_row;

  assign start    = (state == ST_IDLE) && cmd_valid && res_room;
  assign cmd_pop  = start;
  assign last_col = (x == x_last);
  assign last_pix = last_col && (y == y_last);
  assign next_row = row + fbrf_pkg::ADDR_W'(stride);
  assign step     = (state == ST_FILL) || (state == ST_INV_WR);

  always_comb begin
    state_next     = state;
    mem_we         = 1'b0;
    mem_waddr      = cur[AW-1:0];
    mem_wdata      = color;
    mem_raddr      = (state == ST_IDLE) ? cmd.addr[AW-1:0] : cur[AW-1:0];
    res_push       = 1'b0;
    res.read_value = '0;
    res.status     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.op)
            fbrf_pkg::OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = cmd.addr[AW-1:0];
              mem_wdata = cmd.color;
              res_push  = 1'b1;
            end
            fbrf_pkg::OP_READ:   state_next = ST_READ;
            fbrf_pkg::OP_FILL:   state_next = ST_FILL;
            fbrf_pkg::OP_INVERT: state_next = ST_INV_RD;
            default: begin
              res_push   = 1'b1;
              res.status = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push       = 1'b1;
        res.read_value = rdata;
        state_next     = ST_IDLE;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (last_pix) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_INV_RD: state_next = ST_INV_WR;
      ST_INV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ~rdata;
        if (last_pix) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_INV_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rectangle walk: the column runs first, and each new row starts one
  // stride past the start of the previous one.
  always_ff @(posedge clk) begin
    if (start) begin
      cur     <= cmd.addr;
      row     <= cmd.addr;
      x       <= cmd.x_first;
      y       <= cmd.y_first;
      x_first <= cmd.x_first;
      x_last  <= cmd.x_last;
      y_last  <= cmd.y_last;
      color   <= cmd.color;
    end else if (step && !last_pix) begin
      if (last_col) begin
        row <= next_row;
        cur <= next_row;
        x   <= x_first;
        y   <= y + 1'b1;
      end else begin
        cur <= cur + 1'b1;
        x   <= x + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

endmodule

### rtl/fbrf_checker.sv
// ----------------------------------------------------------------------------
// fbrf_checker
// Port-level checks of the fill engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fbrf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             push,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input logic [7:0]                       read_value,
  input logic                             status,
  input logic                             cfg_we,
  input logic [fbrf_pkg::CFG_INDEX_W-1:0] cfg_index
);

  // Requests taken in minus results taken out.
  logic [3:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'((push && !full) ? 1 : 0)
                                 - 4'((pop && !empty) ? 1 : 0);
    end
  end

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A rejected word never carries pixel data.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (read_value == 8'd0))
    else $error("rejected result with nonzero read_value");

  // A waiting result holds until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(read_value) && $stable(status)))
    else $error("waiting result changed");

  // No result without a request that is still owed one.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (outstanding != 4'd0))
    else $error("result word without a pending request");

  // Full means the whole command queue is occupied by owed requests.
  a_full_owed: assert property (@(posedge clk) disable iff (rst || cfg_we)
    full |-> (32'(outstanding) >= fbrf_pkg::CMDQ_DEPTH))
    else $error("full with too few pending requests, index %0d", cfg_index);

endmodule

bind framebuffer_rect_fill_engine_top fbrf_checker u_fbrf_checker (.*);
